FILE: sv/lzx_pretree_length_decoder_assert.svh
// Assertion macros for the LZX pretree length decoder, used by lzxpt_ctrl.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef LZX_PRETREE_LENGTH_DECODER_ASSERT_SVH
`define LZX_PRETREE_LENGTH_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LZX_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LZX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lzxpt_pkg.sv
// Shared types and constants for the LZX pretree length decoder.
// No dependencies; used by every module of the block but lzxpt_ram.
`default_nettype none
package lzxpt_pkg;

  localparam int PRETREE_SYMBOLS = 20;
  localparam int MAX_CODE_BITS   = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int LIST_MAX        = 1024;
  localparam int SYM_MOD         = 17;

  typedef enum logic [1:0] {
    OP_LOAD_PREV = 2'd0,
    OP_START     = 2'd1,
    OP_WORD      = 2'd2,
    OP_END       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRETREE = 2'd1,
    PH_DECODE  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    SUB_SYM  = 3'd0,
    SUB_Z4   = 3'd1,
    SUB_Z5   = 3'd2,
    SUB_RBIT = 3'd3,
    SUB_RSYM = 3'd4
  } sub_t;

  typedef enum logic [1:0] {
    ST_WAIT  = 2'd0,
    ST_FETCH = 2'd1,
    ST_STEP  = 2'd2,
    ST_BUILD = 2'd3
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic build;
  } cmd_t;

  typedef struct packed {
    logic blocked;
    logic emits;
    logic build_req;
    logic build_done;
    logic cap;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: sv/lzxpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lzxpt_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/lzxpt_datapath.sv
// Datapath: bit buffer, pretree tables, canonical symbol match, run
// clipping, previous-length store and result register. Uses lzxpt_pkg, lzxpt_ram.
`default_nettype none
module lzxpt_datapath #(
  parameter int PREV_DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lzxpt_pkg::cmd_t    cmd,
  output lzxpt_pkg::sts_t         sts,
  input  wire logic [1:0]         in_op,
  input  wire logic [9:0]         in_idx,
  input  wire logic [4:0]         in_val,
  input  wire logic [10:0]        in_cnt,
  input  wire logic [15:0]        in_word,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [9:0]              out_run_start,
  output logic [5:0]              out_run_len,
  output logic [4:0]              out_length_value,
  output logic                    out_last,
  output logic                    out_status
);

  localparam int AW = $clog2(PREV_DEPTH);
  localparam int SW = 13;

  logic [31:0]             buf_r, buf_nxt;
  logic [5:0]              bits_r, bits_nxt;
  logic [10:0]             pos_r, pos_nxt;
  logic [9:0]              base_r, base_nxt;
  logic [10:0]             tgt_r, tgt_nxt;
  lzxpt_pkg::phase_t       phase_r, phase_nxt;
  lzxpt_pkg::sub_t         sub_r, sub_nxt;
  logic [4:0]              rc_r, rc_nxt;
  logic                    pbit_r, pbit_nxt;
  logic                    err_r, err_nxt;
  logic [4:0]              res_r;
  logic [3:0]              bld_r;
  logic [21:0]             code_r;
  logic [4:0]              slot_r;

  logic [3:0]              plen_r [lzxpt_pkg::PRETREE_SYMBOLS];
  logic [4:0]              rank_r [lzxpt_pkg::PRETREE_SYMBOLS];
  logic [4:0]              cnt_r  [lzxpt_pkg::MAX_CODE_BITS];
  logic [21:0]             fc_r   [lzxpt_pkg::MAX_CODE_BITS];
  logic [4:0]              fs_r   [lzxpt_pkg::MAX_CODE_BITS];

  logic                    ov_r;
  logic [9:0]              ostart_r;
  logic [5:0]              olen_r;
  logic [4:0]              oval_r;
  logic                    olast_r, ostat_r;

  // Symbol match.
  logic [15:0]             cw;
  logic [4:0]              cl;
  logic                    hit, take_ok;
  logic [3:0]              hj;
  logic [4:0]              hoff, hlen, sym;
  logic [5:0]              hidx;

  // Step evaluation.
  logic                    blocked, emits, build_req;
  logic [5:0]              run_req, run_c;
  logic [4:0]              val_req, dn;
  logic [10:0]             rem;
  logic                    last_c;
  logic [4:0]              prev_q, pm, dm, delta;
  logic [SW-1:0]           rd_sum, wr_ext;
  logic [21:0]             code_b;
  logic [4:0]              slot_b;
  logic [3:0]              pt_v;

  assign rd_sum = SW'(base_r) + SW'(pos_r);
  assign wr_ext = SW'(in_idx);

  // Store depth must be a power of two, not enforced here; index wraps by truncation.
  lzxpt_ram #(.WIDTH(5), .DEPTH(PREV_DEPTH)) u_prev (
    .clk   (clk),
    .we    (cmd.load && (lzxpt_pkg::op_t'(in_op) == lzxpt_pkg::OP_LOAD_PREV)),
    .waddr (wr_ext[AW-1:0]),
    .wdata (in_val),
    .raddr (rd_sum[AW-1:0]),
    .rdata (prev_q)
  );

  // Canonical decode: every code length is tried at once and the shortest match wins.
  always_comb begin
    hit  = 1'b0;
    hj   = '0;
    hoff = '0;
    cw   = '0;
    cl   = '0;
    for (int j = 0; j < lzxpt_pkg::MAX_CODE_BITS; j++) begin
      cw = buf_r[31:16] >> (15 - j);
      cl = (j < lzxpt_pkg::MAX_CODE_BITS - 1) ? cnt_r[4'(j + 1)] : 5'd0;
      if (!hit && (bits_r >= 6'(j + 1)) && (cl != 5'd0) &&
          (22'(cw) >= fc_r[j]) && ((22'(cw) - fc_r[j]) < 22'(cl))) begin
        hit  = 1'b1;
        hj   = 4'(j);
        hoff = 5'(22'(cw) - fc_r[j]);
      end
    end
    hlen    = 5'(hj) + 5'd1;
    hidx    = 6'(fs_r[hj]) + 6'(hoff);
    take_ok = hit && (hidx < 6'(lzxpt_pkg::PRETREE_SYMBOLS));
    sym     = '0;
    for (int s = 0; s < lzxpt_pkg::PRETREE_SYMBOLS; s++) begin
      if ((5'(plen_r[s]) == hlen) && (rank_r[s] == hoff)) begin
        sym = 5'(s);
      end
    end
  end

  always_comb begin
    pm    = (prev_q >= 5'(lzxpt_pkg::SYM_MOD)) ? prev_q - 5'(lzxpt_pkg::SYM_MOD) : prev_q;
    dm    = (sym >= 5'(lzxpt_pkg::SYM_MOD)) ? sym - 5'(lzxpt_pkg::SYM_MOD) : sym;
    delta = (pm >= dm) ? pm - dm : pm + 5'(lzxpt_pkg::SYM_MOD) - dm;
  end

  always_comb begin
    code_b = (code_r + 22'(cnt_r[bld_r])) << 1;
    slot_b = slot_r + ((bld_r == 4'd15) ? 5'd0 : cnt_r[bld_r + 4'd1]);
    pt_v   = buf_r[31:28];
  end

  always_comb begin
    blocked   = 1'b1;
    emits     = 1'b0;
    build_req = 1'b0;
    run_req   = '0;
    val_req   = '0;
    dn        = '0;
    if (err_r) begin
      blocked = 1'b0;
      emits   = 1'b1;
    end else begin
      case (phase_r)
        lzxpt_pkg::PH_PRETREE: begin
          if (bits_r >= 6'd4) begin
            blocked   = 1'b0;
            dn        = 5'd4;
            build_req = (rc_r == 5'(lzxpt_pkg::PRETREE_SYMBOLS - 1)) && (tgt_r != 11'd0);
          end
        end
        lzxpt_pkg::PH_DECODE: begin
          case (sub_r)
            lzxpt_pkg::SUB_SYM: begin
              if (take_ok) begin
                blocked = 1'b0;
                dn      = hlen;
                emits   = (sym < 5'(lzxpt_pkg::SYM_MOD));
                run_req = 6'd1;
                val_req = delta;
              end
            end
            lzxpt_pkg::SUB_Z4: begin
              if (bits_r >= 6'd4) begin
                blocked = 1'b0;
                emits   = 1'b1;
                dn      = 5'd4;
                run_req = 6'(buf_r[31:28]) + 6'd4;
              end
            end
            lzxpt_pkg::SUB_Z5: begin
              if (bits_r >= 6'd5) begin
                blocked = 1'b0;
                emits   = 1'b1;
                dn      = 5'd5;
                run_req = 6'(buf_r[31:27]) + 6'd20;
              end
            end
            lzxpt_pkg::SUB_RBIT: begin
              if (bits_r >= 6'd1) begin
                blocked = 1'b0;
                dn      = 5'd1;
              end
            end
            lzxpt_pkg::SUB_RSYM: begin
              if (take_ok) begin
                blocked = 1'b0;
                emits   = 1'b1;
                dn      = hlen;
                run_req = 6'd4 + 6'(pbit_r);
                val_req = delta;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    rem    = tgt_r - pos_r;
    run_c  = (11'(run_req) > rem) ? rem[5:0] : run_req;
    last_c = (pos_r + 11'(run_c)) >= tgt_r;
  end

  always_comb begin
    buf_nxt   = buf_r;
    bits_nxt  = bits_r;
    pos_nxt   = pos_r;
    base_nxt  = base_r;
    tgt_nxt   = tgt_r;
    phase_nxt = phase_r;
    sub_nxt   = sub_r;
    rc_nxt    = rc_r;
    pbit_nxt  = pbit_r;
    err_nxt   = err_r;
    if (cmd.step && !blocked) begin
      buf_nxt  = buf_r << dn;
      bits_nxt = bits_r - 6'(dn);
      if (err_r) begin
        err_nxt = 1'b0;
      end else if (phase_r == lzxpt_pkg::PH_PRETREE) begin
        rc_nxt = rc_r + 5'd1;
        if (rc_r == 5'(lzxpt_pkg::PRETREE_SYMBOLS - 1)) begin
          sub_nxt   = lzxpt_pkg::SUB_SYM;
          phase_nxt = (tgt_r == 11'd0) ? lzxpt_pkg::PH_IDLE : lzxpt_pkg::PH_DECODE;
        end
      end else if (emits) begin
        pos_nxt = pos_r + 11'(run_c);
        sub_nxt = lzxpt_pkg::SUB_SYM;
        if (last_c) begin
          phase_nxt = lzxpt_pkg::PH_IDLE;
        end
      end else if (sub_r == lzxpt_pkg::SUB_SYM) begin
        sub_nxt = lzxpt_pkg::sub_t'(3'(sym - 5'd16));
      end else begin
        pbit_nxt = buf_r[31];
        sub_nxt  = lzxpt_pkg::SUB_RSYM;
      end
    end
    if (cmd.load) begin
      case (lzxpt_pkg::op_t'(in_op))
        lzxpt_pkg::OP_START: begin
          base_nxt  = in_idx;
          tgt_nxt   = (in_cnt > 11'(lzxpt_pkg::LIST_MAX)) ? 11'(lzxpt_pkg::LIST_MAX) : in_cnt;
          pos_nxt   = '0;
          rc_nxt    = '0;
          pbit_nxt  = 1'b0;
          sub_nxt   = lzxpt_pkg::SUB_SYM;
          phase_nxt = lzxpt_pkg::PH_PRETREE;
        end
        lzxpt_pkg::OP_WORD: begin
          // A word that arrives while more than half the buffer is held is dropped.
          if (bits_r <= 6'd16) begin
            buf_nxt  = buf_r | ({in_word, 16'h0000} >> bits_r);
            bits_nxt = bits_r + 6'd16;
          end
        end
        lzxpt_pkg::OP_END: begin
          buf_nxt  = '0;
          bits_nxt = '0;
          sub_nxt  = lzxpt_pkg::SUB_SYM;
          if (phase_r != lzxpt_pkg::PH_IDLE) begin
            phase_nxt = lzxpt_pkg::PH_IDLE;
            err_nxt   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r   <= '0;
      bits_r  <= '0;
      pos_r   <= '0;
      base_r  <= '0;
      tgt_r   <= '0;
      phase_r <= lzxpt_pkg::PH_IDLE;
      sub_r   <= lzxpt_pkg::SUB_SYM;
      rc_r    <= '0;
      pbit_r  <= 1'b0;
      err_r   <= 1'b0;
      res_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      buf_r   <= buf_nxt;
      bits_r  <= bits_nxt;
      pos_r   <= pos_nxt;
      base_r  <= base_nxt;
      tgt_r   <= tgt_nxt;
      phase_r <= phase_nxt;
      sub_r   <= sub_nxt;
      rc_r    <= rc_nxt;
      pbit_r  <= pbit_nxt;
      err_r   <= err_nxt;
      if (cmd.load) begin
        // A store write resumes no decoding, so it starts at the result limit.
        res_r <= (lzxpt_pkg::op_t'(in_op) == lzxpt_pkg::OP_LOAD_PREV) ?
                 5'(lzxpt_pkg::MAX_RESULTS) : 5'd0;
      end else if (cmd.step && emits) begin
        res_r <= res_r + 5'd1;
      end
      if (cmd.step && emits) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Tables and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load && (lzxpt_pkg::op_t'(in_op) == lzxpt_pkg::OP_START)) begin
      for (int k = 0; k < lzxpt_pkg::MAX_CODE_BITS; k++) begin
        cnt_r[k] <= '0;
      end
    end else if (cmd.step && !blocked && !err_r && (phase_r == lzxpt_pkg::PH_PRETREE)) begin
      plen_r[rc_r] <= pt_v;
      rank_r[rc_r] <= cnt_r[pt_v];
      if (pt_v != 4'd0) begin
        cnt_r[pt_v] <= cnt_r[pt_v] + 5'd1;
      end
    end
    if (cmd.step && build_req) begin
      bld_r  <= '0;
      code_r <= '0;
      slot_r <= '0;
    end else if (cmd.build) begin
      fc_r[bld_r] <= code_b;
      fs_r[bld_r] <= slot_r;
      code_r      <= code_b;
      slot_r      <= slot_b;
      bld_r       <= bld_r + 4'd1;
    end
    if (cmd.step && emits) begin
      ostart_r <= rd_sum[9:0];
      olen_r   <= err_r ? 6'd0 : run_c;
      oval_r   <= err_r ? 5'd0 : val_req;
      olast_r  <= err_r ? 1'b0 : last_c;
      ostat_r  <= err_r;
    end
  end

  always_comb begin
    sts.blocked    = blocked;
    sts.emits      = emits;
    sts.build_req  = build_req;
    sts.build_done = (bld_r == 4'd15);
    sts.cap        = (res_r == 5'(lzxpt_pkg::MAX_RESULTS));
    sts.out_free   = !ov_r || out_ready;
  end

  assign out_valid        = ov_r;
  assign out_run_start    = ostart_r;
  assign out_run_len      = olen_r;
  assign out_length_value = oval_r;
  assign out_last         = olast_r;
  assign out_status       = ostat_r;

endmodule
`default_nettype wire

FILE: sv/lzxpt_ctrl.sv
// Controller state machine: accepts requests and sequences fetch, decode
// steps and code construction. Uses lzxpt_pkg and the assertion macro header.
`default_nettype none
`include "lzx_pretree_length_decoder_assert.svh"
module lzxpt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire lzxpt_pkg::sts_t sts,
  output lzxpt_pkg::cmd_t      cmd
);

  lzxpt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzxpt_pkg::ST_WAIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      lzxpt_pkg::ST_WAIT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = lzxpt_pkg::ST_FETCH;
        end
      end
      // Gives the registered previous-length read time to settle.
      lzxpt_pkg::ST_FETCH: begin
        state_nxt = lzxpt_pkg::ST_STEP;
      end
      lzxpt_pkg::ST_STEP: begin
        if (sts.cap || sts.blocked) begin
          state_nxt = lzxpt_pkg::ST_WAIT;
        end else if (!sts.emits || sts.out_free) begin
          cmd.step = 1'b1;
          if (sts.build_req) begin
            state_nxt = lzxpt_pkg::ST_BUILD;
          end else if (sts.emits) begin
            state_nxt = lzxpt_pkg::ST_FETCH;
          end
        end
      end
      lzxpt_pkg::ST_BUILD: begin
        cmd.build = 1'b1;
        if (sts.build_done) begin
          state_nxt = lzxpt_pkg::ST_STEP;
        end
      end
      default: state_nxt = lzxpt_pkg::ST_WAIT;
    endcase
  end

  `LZX_ASSERT_IMPLY(a_emit_room, cmd.step && sts.emits, sts.out_free, "result lost")
  `LZX_ASSERT_IMPLY(a_cap_stops, sts.cap, !cmd.step, "step past result limit")
  `LZX_ASSERT_NEXT(a_fetch_step, state_r == lzxpt_pkg::ST_FETCH, state_r == lzxpt_pkg::ST_STEP, "fetch not followed by step")
  `LZX_ASSERT_NEXT(a_build_end, cmd.build && sts.build_done, state_r == lzxpt_pkg::ST_STEP, "build did not end")

endmodule
`default_nettype wire

FILE: sv/lzx_pretree_length_decoder.sv
// Usage:
// Requests arrive on the in_ channel (tuser = opcode): load a previous
// length, start a list, deliver a 16-bit stream word, or end the input.
// Decoded runs leave on the out_ channel through a single result register.
// Each accepted request is followed by a store read, then by decode steps
// (pretree nibble, symbol, extra bits) with a store read after each emitted
// run, and it ends when the controller finds no step it can take.
// A store write decodes nothing. After the twentieth pretree length of a
// nonempty list the code tables are built. At most 16 runs come from one
// request; further runs wait for the next stream word. in_tready is high
// only while the block waits for a request. When the receiver stalls, the
// result register holds and decoding pauses at the next run. Reset empties
// the bit buffer and idles the decoder; the previous-length store keeps no
// reset value. PREV_DEPTH must be a power of two; the block does not
// enforce it.
`default_nettype none
module lzx_pretree_length_decoder #(
  parameter int PREV_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [9:0] entry_index, [14:10] entry_value, [25:15] element_count,
  // [41:26] stream_word, [47:42] zero
  input  wire logic [47:0] in_tdata,
  // [1:0] opcode
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [9:0] run_start, [15:10] run_len, [20:16] length_value, [23:21] zero
  output logic [23:0]      out_tdata,
  output logic             out_tlast,
  // [0] status
  output logic             out_tuser
);

  lzxpt_pkg::cmd_t cmd;
  lzxpt_pkg::sts_t sts;
  logic [9:0]      run_start;
  logic [5:0]      run_len;
  logic [4:0]      length_value;

  lzxpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzxpt_datapath #(.PREV_DEPTH(PREV_DEPTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_tuser),
    .in_idx           (in_tdata[9:0]),
    .in_val           (in_tdata[14:10]),
    .in_cnt           (in_tdata[25:15]),
    .in_word          (in_tdata[41:26]),
    .out_ready        (out_tready),
    .out_valid        (out_tvalid),
    .out_run_start    (run_start),
    .out_run_len      (run_len),
    .out_length_value (length_value),
    .out_last         (out_tlast),
    .out_status       (out_tuser)
  );

  assign out_tdata = {3'b000, length_value, run_len, run_start};

endmodule
`default_nettype wire

FILE: tb/sv/lzx_pretree_length_decoder_tb.sv
// Self-checking testbench for the LZX pretree length decoder: encodes code-length
// lists with canonical pretrees, drives them as requests and checks every decoded run.
// Depends on lzxpt_pkg and the lzx_pretree_length_decoder top level.
`default_nettype none
module lzx_pretree_length_decoder_tb;
  import lzxpt_pkg::*;

  localparam int STORE_DEPTH = 1024;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 200;
  localparam int ITEM_TARGET = 460;

  typedef struct {
    op_t       op;
    bit [9:0]  idx;
    bit [4:0]  val;
    bit [10:0] cnt;
    bit [15:0] word;
  } req_t;

  typedef struct {
    bit [9:0] start;
    bit [5:0] len;
    bit [4:0] val;
    bit       last;
    bit       status;
  } run_t;

  class run_scoreboard;
    bit [4:0]  prev_len [STORE_DEPTH];
    bit        written [STORE_DEPTH];
    bit [3:0]  pt_len [PRETREE_SYMBOLS];
    bit [31:0] bbuf;
    int        held, pos, base, target, nread, pend_run;
    phase_t    phase;
    sub_t      sub;
    int        cnt_len [MAX_CODE_BITS+1];
    int        fcode [MAX_CODE_BITS+1];
    int        fslot [MAX_CODE_BITS+1];
    int        sorted [PRETREE_SYMBOLS];
    int        missing [$];
    run_t      pending_runs [$];
    int        errors, matched;

    function new();
      phase = PH_IDLE;
      sub   = SUB_SYM;
    endfunction

    function void drop(int n);
      bbuf = (n >= 32) ? 32'd0 : (bbuf << n);
      held -= n;
    endfunction

    function void build();
      int code, slot;
      code = 0;
      slot = 0;
      foreach (cnt_len[l]) cnt_len[l] = 0;
      for (int s = 0; s < PRETREE_SYMBOLS; s++) cnt_len[pt_len[s]]++;
      cnt_len[0] = 0;
      for (int l = 1; l <= MAX_CODE_BITS; l++) begin
        code = (code + cnt_len[l-1]) << 1;
        fcode[l] = code;
        fslot[l] = slot;
        for (int s = 0; s < PRETREE_SYMBOLS; s++)
          if (pt_len[s] == l && slot < PRETREE_SYMBOLS) begin
            sorted[slot] = s;
            slot++;
          end
      end
    endfunction

    function bit take(output int sym);
      int c, k;
      sym = 0;
      for (int l = 1; l <= MAX_CODE_BITS && l <= held; l++) begin
        c = int'(bbuf >> (32 - l));
        if (cnt_len[l] != 0 && c >= fcode[l] && c - fcode[l] < cnt_len[l]) begin
          k = fslot[l] + c - fcode[l];
          if (k >= PRETREE_SYMBOLS) return 0;
          sym = sorted[k];
          drop(l);
          return 1;
        end
      end
      return 0;
    endfunction

    // Entries never loaded are noted so that the stimulus can load them first.
    function int delta(int d);
      int a, p;
      a = (base + pos) % STORE_DEPTH;
      if (!written[a]) begin
        missing.push_back(a);
        written[a] = 1;
      end
      p = prev_len[a] % SYM_MOD;
      return (p + SYM_MOD - (d % SYM_MOD)) % SYM_MOD;
    endfunction

    function void emit(int run, int val);
      run_t r;
      if (run > target - pos) run = target - pos;
      r.start  = 10'((base + pos) % STORE_DEPTH);
      r.len    = 6'(run);
      r.val    = 5'(val);
      r.last   = (pos + run >= target);
      r.status = 0;
      pending_runs.push_back(r);
      pos += run;
      sub = SUB_SYM;
      if (r.last) phase = PH_IDLE;
    endfunction

    function void decode();
      int  n, sym;
      bit  go;
      n  = 0;
      go = 1;
      while (go && n < MAX_RESULTS) begin
        case (phase)
          PH_PRETREE: begin
            if (held < 4) go = 0;
            else begin
              pt_len[nread] = bbuf[31:28];
              drop(4);
              nread++;
              if (nread >= PRETREE_SYMBOLS) begin
                build();
                sub   = SUB_SYM;
                phase = (target == 0) ? PH_IDLE : PH_DECODE;
              end
            end
          end
          PH_DECODE: begin
            case (sub)
              SUB_SYM: begin
                if (!take(sym)) go = 0;
                else if (sym < SYM_MOD) begin
                  emit(1, delta(sym));
                  n++;
                end else sub = sub_t'(sym - 16);
              end
              SUB_Z4: begin
                if (held < 4) go = 0;
                else begin
                  sym = bbuf[31:28] + 4;
                  drop(4);
                  emit(sym, 0);
                  n++;
                end
              end
              SUB_Z5: begin
                if (held < 5) go = 0;
                else begin
                  sym = bbuf[31:27] + 20;
                  drop(5);
                  emit(sym, 0);
                  n++;
                end
              end
              SUB_RBIT: begin
                if (held < 1) go = 0;
                else begin
                  pend_run = bbuf[31] + 4;
                  drop(1);
                  sub = SUB_RSYM;
                end
              end
              default: begin
                if (!take(sym)) go = 0;
                else begin
                  emit(pend_run, delta(sym));
                  n++;
                end
              end
            endcase
          end
          default: go = 0;
        endcase
      end
    endfunction

    function void note_request(req_t r);
      bit [31:0] w32;
      run_t      e;
      case (r.op)
        OP_LOAD_PREV: begin
          prev_len[r.idx] = r.val;
          written[r.idx]  = 1;
        end
        OP_START: begin
          base     = r.idx;
          target   = (r.cnt > LIST_MAX) ? LIST_MAX : r.cnt;
          pos      = 0;
          nread    = 0;
          sub      = SUB_SYM;
          pend_run = 0;
          phase    = PH_PRETREE;
          decode();
        end
        OP_WORD: begin
          if (held <= 16) begin
            w32  = {16'd0, r.word};
            bbuf |= w32 << (16 - held);
            held += 16;
          end
          decode();
        end
        default: begin
          bbuf = 0;
          held = 0;
          sub  = SUB_SYM;
          if (phase != PH_IDLE) begin
            phase    = PH_IDLE;
            e.start  = 10'((base + pos) % STORE_DEPTH);
            e.len    = 0;
            e.val    = 0;
            e.last   = 0;
            e.status = 1;
            pending_runs.push_back(e);
          end
        end
      endcase
    endfunction

    function void check_run(run_t got);
      run_t e;
      if (pending_runs.size() == 0) begin
        errors++;
        $display("%0t: unexpected run start %0d len %0d value %0d last %0d status %0d",
                 $time, got.start, got.len, got.val, got.last, got.status);
        return;
      end
      e = pending_runs.pop_front();
      if (got.start != e.start || got.len != e.len || got.val != e.val ||
          got.last != e.last || got.status != e.status) begin
        errors++;
        $display("%0t: run mismatch, expected start %0d len %0d value %0d last %0d status %0d",
                 $time, e.start, e.len, e.val, e.last, e.status);
        $display("%0t:                  actual start %0d len %0d value %0d last %0d status %0d",
                 $time, got.start, got.len, got.val, got.last, got.status);
      end else matched++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  lzx_pretree_length_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  run_scoreboard sb = new();
  run_scoreboard planner;
  req_t          plan_q [$];
  bit            enc_bits [$];
  int            code_of [PRETREE_SYMBOLS];
  int            len_of [PRETREE_SYMBOLS];
  int            coded [$];
  int            items_sent;
  int            lists_started;
  int            stall_cycles;
  bit            calm;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  assign calm = (items_sent >= 150 && items_sent < 260);

  always @(posedge clk) begin
    run_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.start  = out_tdata[9:0];
      got.len    = out_tdata[15:10];
      got.val    = out_tdata[20:16];
      got.last   = out_tlast;
      got.status = out_tuser;
      sb.check_run(got);
    end
    out_tready <= rst_n && (calm || $urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) stall_cycles <= 0;
    else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no request or run accepted for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else stall_cycles <= stall_cycles + 1;
  end

  function automatic req_t mk_req(op_t op);
    req_t r;
    r.op   = op;
    r.idx  = 10'($urandom);
    r.val  = 5'($urandom);
    r.cnt  = 11'($urandom);
    r.word = 16'($urandom);
    return r;
  endfunction

  task automatic send_req(req_t r);
    if (!calm)
      while ($urandom_range(99) < 30) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    in_tvalid <= 1'b1;
    in_tuser  <= r.op;
    in_tdata  <= {6'd0, r.word, r.cnt, r.val, r.idx};
    do @(posedge clk); while (!in_tready);
    sb.note_request(r);
    if (r.op == OP_START) lists_started++;
    items_sent++;
  endtask

  // Either twelve 4-bit and eight 5-bit codes, or a deep 1..15 ladder with
  // four unused symbols; both are complete prefix codes.
  function automatic void pick_pretree();
    int lens [PRETREE_SYMBOLS];
    int j, t, code;
    bit ladder;
    ladder = ($urandom_range(3) == 0);
    for (int s = 0; s < PRETREE_SYMBOLS; s++)
      if (ladder) lens[s] = (s < 15) ? s + 1 : (s == 15) ? 15 : 0;
      else lens[s] = (s < 12) ? 4 : 5;
    for (int s = PRETREE_SYMBOLS - 1; s > 0; s--) begin
      j = $urandom_range(s);
      t = lens[s];
      lens[s] = lens[j];
      lens[j] = t;
    end
    code = 0;
    coded.delete();
    for (int l = 1; l <= 15; l++) begin
      for (int s = 0; s < PRETREE_SYMBOLS; s++)
        if (lens[s] == l) begin
          code_of[s] = code;
          code++;
        end
      code = code << 1;
    end
    for (int s = 0; s < PRETREE_SYMBOLS; s++) begin
      len_of[s] = lens[s];
      if (lens[s] != 0) coded.push_back(s);
    end
  endfunction

  function automatic void push_bits(int v, int n);
    for (int i = n - 1; i >= 0; i--) enc_bits.push_back(v[i]);
  endfunction

  function automatic int any_coded();
    return coded[$urandom_range(coded.size() - 1)];
  endfunction

  // Encodes one list into plan_q; a cut below the clipped count may leave it open.
  function automatic void plan_list(int base, int cnt, int cut, bit prefix, bit big);
    req_t r;
    int   stop, pos, s, x;
    bit   started;
    pick_pretree();
    enc_bits.delete();
    for (int s2 = 0; s2 < PRETREE_SYMBOLS; s2++) push_bits(len_of[s2], 4);
    stop = (cnt > LIST_MAX) ? LIST_MAX : cnt;
    if (cut < stop) stop = cut;
    pos = 0;
    while (pos < stop) begin
      s = any_coded();
      if (big && len_of[18] != 0 && $urandom_range(9) < 8) s = 18;
      push_bits(code_of[s], len_of[s]);
      if (s < 17) pos += 1;
      else if (s == 17) begin
        x = $urandom_range(15);
        push_bits(x, 4);
        pos += x + 4;
      end else if (s == 18) begin
        x = $urandom_range(31);
        push_bits(x, 5);
        pos += x + 20;
      end else begin
        x = $urandom_range(1);
        push_bits(x, 1);
        s = any_coded();
        push_bits(code_of[s], len_of[s]);
        pos += x + 4;
      end
    end
    started = !prefix;
    if (!prefix) begin
      r = mk_req(OP_START);
      r.idx = 10'(base);
      r.cnt = 11'(cnt);
      plan_q.push_back(r);
    end
    while (enc_bits.size() > 0) begin
      r = mk_req(OP_WORD);
      for (int i = 15; i >= 0; i--)
        r.word[i] = (enc_bits.size() > 0) ? enc_bits.pop_front() : 1'($urandom);
      plan_q.push_back(r);
      // A word sent before the start stays buffered for the new list.
      if (!started) begin
        r = mk_req(OP_START);
        r.idx = 10'(base);
        r.cnt = 11'(cnt);
        plan_q.push_back(r);
        started = 1;
      end
      if ($urandom_range(9) == 0) plan_q.push_back(mk_req(OP_LOAD_PREV));
    end
  endfunction

  // Dry-runs the plan on a copy of the scoreboard so that every store entry
  // the plan will read is loaded beforehand.
  task automatic run_plan();
    req_t r;
    planner = new sb;
    planner.missing.delete();
    foreach (plan_q[i]) planner.note_request(plan_q[i]);
    foreach (planner.missing[i]) begin
      r = mk_req(OP_LOAD_PREV);
      r.idx = 10'(planner.missing[i]);
      r.val = ($urandom_range(9) == 0) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(16));
      send_req(r);
    end
    foreach (plan_q[i]) send_req(plan_q[i]);
    plan_q.delete();
  endtask

  initial begin
    req_t r;
    int   kind, cnt, n;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    out_tready   = 1'b0;
    items_sent   = 0;
    lists_started = 0;
    stall_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Store extremes, including a value above the largest code length.
    r = mk_req(OP_LOAD_PREV); r.idx = 0;    r.val = 0;  send_req(r);
    r = mk_req(OP_LOAD_PREV); r.idx = 1023; r.val = 16; send_req(r);
    r = mk_req(OP_LOAD_PREV); r.idx = 1022; r.val = 31; send_req(r);
    // Words while idle, then end of input with no list open.
    plan_q.push_back(mk_req(OP_WORD));
    plan_q.push_back(mk_req(OP_WORD));
    plan_q.push_back(mk_req(OP_END));
    run_plan();
    // An all-zero pretree has no codes: decoding stalls, surplus words are
    // dropped, and end of input reports an error.
    r = mk_req(OP_START); r.cnt = 5; plan_q.push_back(r);
    for (int i = 0; i < 5; i++) begin
      r = mk_req(OP_WORD); r.word = 16'd0; plan_q.push_back(r);
    end
    for (int i = 0; i < 3; i++) plan_q.push_back(mk_req(OP_WORD));
    plan_q.push_back(mk_req(OP_END));
    run_plan();
    // Empty list, then an oversized count that saturates, wrapping the index.
    plan_list($urandom_range(1023), 0, LIST_MAX, 0, 0);
    plan_q.push_back(mk_req(OP_END));
    run_plan();
    plan_list(1020, 2047, LIST_MAX + 1, 0, 1);
    plan_q.push_back(mk_req(OP_END));
    run_plan();
    // A new start abandons the list in progress.
    plan_list($urandom_range(1023), 30, 10, 0, 0);
    plan_list(1015, 12, LIST_MAX, 0, 0);
    plan_q.push_back(mk_req(OP_END));
    run_plan();

    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(99);
      cnt  = ($urandom_range(9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
      if (kind < 70) begin
        if ($urandom_range(29) == 0) plan_list($urandom_range(1023), LIST_MAX, LIST_MAX, 0, 1);
        else plan_list($urandom_range(1023), cnt, LIST_MAX, $urandom_range(4) == 0, 0);
      end else if (kind < 80) begin
        plan_list($urandom_range(1023), cnt, $urandom_range(cnt - 1), 0, 0);
      end else if (kind < 90) begin
        plan_list($urandom_range(1023), cnt, $urandom_range(cnt), 0, 0);
        plan_list($urandom_range(1023), $urandom_range(1, 40), LIST_MAX, 0, 0);
      end else begin
        r = mk_req(OP_START);
        plan_q.push_back(r);
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) plan_q.push_back(mk_req(OP_WORD));
      end
      plan_q.push_back(mk_req(OP_END));
      run_plan();
    end

    in_tvalid <= 1'b0;
    while (sb.pending_runs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d requests opening %0d lists; %0d runs matched, %0d mismatches.",
             items_sent, lists_started, sb.matched, sb.errors);
    if (sb.errors == 0 && sb.pending_runs.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
+incdir+sv
sv/lzxpt_pkg.sv
sv/lzxpt_ram.sv
sv/lzxpt_datapath.sv
sv/lzxpt_ctrl.sv
sv/lzx_pretree_length_decoder.sv
tb/sv/lzx_pretree_length_decoder_tb.sv
